// File: rtl/text_console_writer_core_defines.svh
// Assertion macros used by the text console writer top level.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

`ifndef SYNTH
// Overlapping implication: when ante holds, cons must hold at the same edge.
`define TCW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text console writer: implication check failed");
// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text console writer: next-cycle check failed");
// Invariant that must hold at every edge outside reset.
`define TCW_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("text console writer: invariant check failed");
`else
`define TCW_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons)
`define TCW_ASSERT_ALWAYS(label, clk, rst, cond)
`endif

`endif

// File: rtl/tcw_pkg.sv
// Types and constants shared by the text console writer modules.
package tcw_pkg;

   localparam int MODE_W = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int IDX_W  = 11;
   localparam int OFS_W  = 11;
   localparam int CELL_W = ATTR_W + CHAR_W;

   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

   typedef enum logic [MODE_W-1:0] {
      MODE_PRINT = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic {
      PTR_ZERO,
      PTR_CURSOR
   } ptr_src_type;

   typedef enum logic {
      WA_PTR,
      WA_CURSOR
   } wr_addr_type;

   typedef enum logic [1:0] {
      WD_RESET,
      WD_BLANK,
      WD_CHAR
   } wr_data_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_HOME,
      CUR_NEXT_COL,
      CUR_NEXT_LINE
   } cursor_op_type;

   typedef struct packed {
      logic          item_load;
      logic          ptr_load;
      ptr_src_type   ptr_src;
      logic          ptr_inc;
      logic          wr_en;
      wr_addr_type   wr_addr;
      wr_data_type   wr_data;
      logic          copy_read;
      logic          read_capture;
      cursor_op_type cursor_op;
      logic          rsp_load;
   } tcw_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     is_newline;
      logic     ptr_at_last_cell;
      logic     ptr_at_row_end;
      logic     ptr_at_copy_end;
      logic     cur_last_col;
      logic     cur_last_row;
      logic     copy_pend;
   } tcw_sts_type;

endpackage

// File: rtl/text_console_writer_core.sv
// Top level of the text console writer: stream ports, controller and datapath.
//
// A character-cell text console of COLUMNS x ROWS cells, each holding a character
// code in its low byte and an attribute in its high byte, with a cursor. Each item
// on the request stream carries a mode in req_tuser: print a byte, read one cell,
// or clear the screen and home the cursor (the fourth code does nothing). Printing
// a newline blanks the rest of the cursor row and moves to the next row; any other
// byte is stored with the current attribute and the cursor advances, wrapping at
// the last column. Moving past the last row scrolls the screen up one row and
// blanks the bottom row. Every item returns exactly one result item carrying the
// cursor offset (row times COLUMNS plus column) after the item, and in read mode
// the addressed cell (zero for an index beyond the screen or in other modes).
// The attribute register is written through csr_we and csr_wdata; write it only
// while no item is in flight. After reset the block fills the screen with spaces
// of attribute 0x0F and keeps req_tready low until that pass is done. All screen
// traffic goes through a single write port and a single registered read port of
// the screen memory, so the cost of an item is set by how many cells it touches.
// Before its result is registered, an ordinary character is written at the
// cursor, a read waits for the registered read port, a newline blanks the cells
// from the cursor to the row end, a clear blanks every cell, and a scroll also
// copies every row but the first up one row and blanks the bottom row. The
// result is held back for as long as the previous result item still waits in the
// output register. The next item can be accepted in the cycle after the result
// is registered. One item is worked on at a time; the next item is taken while a
// finished result still waits in the output register.
`include "text_console_writer_core_defines.svh"

module text_console_writer_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] char_code, [18:8] cell_index, zero padding
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [10:0] cursor_offset, [18:11] read_char,
                                    // [26:19] read_attr, zero padding
   // Attribute register write port.
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);
   import tcw_pkg::*;

   tcw_cmd_type       cmd;
   tcw_sts_type       sts;
   logic [OFS_W-1:0]  rsp_offset;
   logic [CHAR_W-1:0] rsp_char;
   logic [ATTR_W-1:0] rsp_attr;

   // The controller owns the handshakes and the sequencing; it only steers the
   // datapath through the command word and watches its status word.
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the screen memory, the cursor, the walk pointer used for
   // blanking, clearing and scrolling, and the output register of the result.
   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_mode   (req_tuser),
      .req_char   (req_tdata[7:0]),
      .req_index  (req_tdata[18:8]),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_offset (rsp_offset),
      .rsp_char   (rsp_char),
      .rsp_attr   (rsp_attr)
   );

   assign rsp_tdata = {5'd0, rsp_attr, rsp_char, rsp_offset};

   // A delayed copy write during scrolling must never collide with a direct write.
   `TCW_ASSERT_ALWAYS(a_no_write_collision, clock, reset, !(cmd.wr_en && sts.copy_pend))
   // Every accepted request is captured into the datapath in the same cycle.
   `TCW_ASSERT_IMPL(a_accept_loads_item, clock, reset, req_tvalid && req_tready, cmd.item_load)
   // A result is only loaded when the output register is free or being drained.
   `TCW_ASSERT_IMPL(a_rsp_no_overwrite, clock, reset, cmd.rsp_load, !rsp_tvalid || rsp_tready)
   // Leaving reset always starts the clearing pass, so no request is taken at once.
   `TCW_ASSERT_IMPL(a_busy_after_reset, clock, reset, $fell(reset), !req_tready)

endmodule

// File: rtl/tcw_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tcw_datapath.sv
// Datapath of the text console writer: screen store, cursor, walk pointer and result.
module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tcw_pkg::MODE_W-1:0]  req_mode,
   input  logic [tcw_pkg::CHAR_W-1:0]  req_char,
   input  logic [tcw_pkg::IDX_W-1:0]   req_index,
   input  logic                        csr_we,
   input  logic [tcw_pkg::ATTR_W-1:0]  csr_wdata,
   input  tcw_pkg::tcw_cmd_type        cmd,
   output tcw_pkg::tcw_sts_type        sts,
   output logic [tcw_pkg::OFS_W-1:0]   rsp_offset,
   output logic [tcw_pkg::CHAR_W-1:0]  rsp_char,
   output logic [tcw_pkg::ATTR_W-1:0]  rsp_attr
);
   import tcw_pkg::*;

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);

   localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [ADDR_W-1:0] COPY_END      = ADDR_W'((ROWS - 1) * COLUMNS - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP      = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_LAST_OFS  = ADDR_W'(COLUMNS - 1);
   localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);

   mode_type            mode_ff, mode_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic [ADDR_W-1:0]   idx_addr_ff, idx_addr_in;
   logic                in_range_ff, in_range_in;
   logic [ATTR_W-1:0]   attr_ff, attr_in;
   logic [ADDR_W-1:0]   ptr_ff, ptr_in;
   logic [ADDR_W-1:0]   row_base_ff, row_base_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                copy_pend_ff, copy_pend_in;
   logic [ADDR_W-1:0]   copy_addr_ff, copy_addr_in;
   logic [CHAR_W-1:0]   rd_char_ff, rd_char_in;
   logic [ATTR_W-1:0]   rd_attr_ff, rd_attr_in;
   logic [OFS_W-1:0]    rsp_offset_ff, rsp_offset_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]   rsp_attr_ff, rsp_attr_in;

   logic [ADDR_W-1:0]        cur_addr;
   logic [ADDR_W-1:0]        row_end;
   logic [ADDR_W+IDX_W-1:0]  idx_wide;
   logic [ADDR_W+OFS_W-1:0]  ofs_wide;
   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_waddr;
   logic [CELL_W-1:0]        ram_wdata;
   logic [ADDR_W-1:0]        ram_raddr;
   logic [CELL_W-1:0]        ram_rdata;

   assign cur_addr = row_base_ff + ADDR_W'(col_ff);
   assign row_end  = row_base_ff + ROW_LAST_OFS;
   // Zero-extend first, then keep the low bits, so this works for any address width.
   assign idx_wide = {{ADDR_W{1'b0}}, req_index};
   assign ofs_wide = {{OFS_W{1'b0}}, cur_addr};

   // Screen store write and read ports.
   always_comb begin
      ram_we    = cmd.wr_en | copy_pend_ff;
      ram_waddr = (cmd.wr_addr == WA_CURSOR) ? cur_addr : ptr_ff;
      unique case (cmd.wr_data)
         WD_RESET: ram_wdata = {RESET_ATTR, BLANK_CHAR};
         WD_BLANK: ram_wdata = {attr_ff, BLANK_CHAR};
         WD_CHAR:  ram_wdata = {attr_ff, char_ff};
         default:  ram_wdata = {attr_ff, BLANK_CHAR};
      endcase
      if (copy_pend_ff) begin
         ram_waddr = copy_addr_ff;
         ram_wdata = ram_rdata;
      end
      ram_raddr = cmd.copy_read ? (ptr_ff + ROW_STEP) : idx_addr_ff;
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      mode_in       = mode_ff;
      char_in       = char_ff;
      idx_addr_in   = idx_addr_ff;
      in_range_in   = in_range_ff;
      attr_in       = csr_we ? csr_wdata : attr_ff;
      ptr_in        = ptr_ff;
      row_base_in   = row_base_ff;
      col_in        = col_ff;
      copy_pend_in  = cmd.copy_read;
      copy_addr_in  = ptr_ff;
      rd_char_in    = rd_char_ff;
      rd_attr_in    = rd_attr_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;

      if (cmd.item_load) begin
         mode_in     = mode_type'(req_mode);
         char_in     = req_char;
         idx_addr_in = idx_wide[ADDR_W-1:0];
         in_range_in = (32'(req_index) < 32'(CELLS));
         rd_char_in  = '0;
         rd_attr_in  = '0;
      end

      if (cmd.read_capture) begin
         rd_char_in = in_range_ff ? ram_rdata[CHAR_W-1:0] : '0;
         rd_attr_in = in_range_ff ? ram_rdata[CELL_W-1:CHAR_W] : '0;
      end

      if (cmd.ptr_load) begin
         ptr_in = (cmd.ptr_src == PTR_CURSOR) ? cur_addr : '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + ADDR_W'(1);
      end

      case (cmd.cursor_op)
         CUR_HOME: begin
            row_base_in = '0;
            col_in      = '0;
         end
         CUR_NEXT_COL: begin
            col_in = col_ff + COL_W'(1);
         end
         CUR_NEXT_LINE: begin
            col_in = '0;
            // On the last row the screen scrolls instead and the cursor stays there.
            if (row_base_ff != LAST_ROW_BASE) begin
               row_base_in = row_base_ff + ROW_STEP;
            end
         end
         default: begin
         end
      endcase

      if (cmd.rsp_load) begin
         rsp_offset_in = ofs_wide[OFS_W-1:0];
         rsp_char_in   = rd_char_ff;
         rsp_attr_in   = rd_attr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= RESET_ATTR;
         ptr_ff       <= '0;
         row_base_ff  <= '0;
         col_ff       <= '0;
         copy_pend_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         ptr_ff       <= ptr_in;
         row_base_ff  <= row_base_in;
         col_ff       <= col_in;
         copy_pend_ff <= copy_pend_in;
      end
      mode_ff       <= mode_in;
      char_ff       <= char_in;
      idx_addr_ff   <= idx_addr_in;
      in_range_ff   <= in_range_in;
      copy_addr_ff  <= copy_addr_in;
      rd_char_ff    <= rd_char_in;
      rd_attr_ff    <= rd_attr_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_attr_ff   <= rsp_attr_in;
   end

   always_comb begin
      sts.mode             = mode_ff;
      sts.is_newline       = (char_ff == NEWLINE_CHAR);
      sts.ptr_at_last_cell = (ptr_ff == LAST_CELL);
      sts.ptr_at_row_end   = (ptr_ff == row_end);
      sts.ptr_at_copy_end  = (ptr_ff == COPY_END);
      sts.cur_last_col     = (col_ff == LAST_COL);
      sts.cur_last_row     = (row_base_ff == LAST_ROW_BASE);
      sts.copy_pend        = copy_pend_ff;
   end

   assign rsp_offset = rsp_offset_ff;
   assign rsp_char   = rsp_char_ff;
   assign rsp_attr   = rsp_attr_ff;

endmodule

// File: rtl/tcw_ctrl.sv
// Controller of the text console writer: sequences writes, walks and scrolls.
module tcw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  tcw_pkg::tcw_sts_type  sts,
   output tcw_pkg::tcw_cmd_type  cmd
);
   import tcw_pkg::*;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DISPATCH,
      S_READ_WAIT,
      S_NL_BLANK,
      S_SCROLL_COPY,
      S_SCROLL_DRAIN,
      S_SCROLL_BLANK,
      S_CLEAR,
      S_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            // Power-up sweep fills every cell with the reset blank.
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = WA_PTR;
            cmd.wr_data = WD_RESET;
            cmd.ptr_inc = 1'b1;
            if (sts.ptr_at_last_cell) begin
               cmd.ptr_load = 1'b1;
               cmd.ptr_src  = PTR_ZERO;
               state_in     = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.item_load = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.mode)
               MODE_PRINT: begin
                  if (sts.is_newline) begin
                     cmd.ptr_load = 1'b1;
                     cmd.ptr_src  = PTR_CURSOR;
                     state_in     = S_NL_BLANK;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_addr = WA_CURSOR;
                     cmd.wr_data = WD_CHAR;
                     if (sts.cur_last_col) begin
                        cmd.cursor_op = CUR_NEXT_LINE;
                        if (sts.cur_last_row) begin
                           cmd.ptr_load = 1'b1;
                           cmd.ptr_src  = PTR_ZERO;
                           state_in     = S_SCROLL_COPY;
                        end else begin
                           state_in = S_RESPOND;
                        end
                     end else begin
                        cmd.cursor_op = CUR_NEXT_COL;
                        state_in      = S_RESPOND;
                     end
                  end
               end
               MODE_READ: begin
                  state_in = S_READ_WAIT;
               end
               MODE_CLEAR: begin
                  cmd.ptr_load = 1'b1;
                  cmd.ptr_src  = PTR_ZERO;
                  state_in     = S_CLEAR;
               end
               default: begin
                  state_in = S_RESPOND;
               end
            endcase
         end
         S_READ_WAIT: begin
            cmd.read_capture = 1'b1;
            state_in         = S_RESPOND;
         end
         S_NL_BLANK: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = WA_PTR;
            cmd.wr_data = WD_BLANK;
            cmd.ptr_inc = 1'b1;
            if (sts.ptr_at_row_end) begin
               cmd.cursor_op = CUR_NEXT_LINE;
               if (sts.cur_last_row) begin
                  cmd.ptr_load = 1'b1;
                  cmd.ptr_src  = PTR_ZERO;
                  state_in     = S_SCROLL_COPY;
               end else begin
                  state_in = S_RESPOND;
               end
            end
         end
         S_SCROLL_COPY: begin
            cmd.copy_read = 1'b1;
            cmd.ptr_inc   = 1'b1;
            if (sts.ptr_at_copy_end) begin
               state_in = S_SCROLL_DRAIN;
            end
         end
         S_SCROLL_DRAIN: begin
            // The last copied cell is written back here; the pointer sits on the last row.
            state_in = S_SCROLL_BLANK;
         end
         S_SCROLL_BLANK: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = WA_PTR;
            cmd.wr_data = WD_BLANK;
            cmd.ptr_inc = 1'b1;
            if (sts.ptr_at_last_cell) begin
               state_in = S_RESPOND;
            end
         end
         S_CLEAR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = WA_PTR;
            cmd.wr_data = WD_BLANK;
            cmd.ptr_inc = 1'b1;
            if (sts.ptr_at_last_cell) begin
               cmd.cursor_op = CUR_HOME;
               state_in      = S_RESPOND;
            end
         end
         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
